@@ src/irt_pkg.sv @@
package irt_pkg;

  localparam int DEF_VALUE_WIDTH = 32;
  localparam int DEF_MAX_PAD     = 32;

  localparam int DIV_STEPS = 8;
  localparam int RADIX_W   = 6;
  localparam int CHAR_W    = 7;
  localparam int PAD_IN_W  = 6;
  localparam int LEN_W     = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
  localparam logic [RADIX_W-1:0] DIGIT_MAX = 6'd35;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_UPPER = 7'h41;

  typedef enum logic [1:0] {
    EMIT_SIGN,
    EMIT_PAD,
    EMIT_DIGIT
  } emit_kind_e;

  typedef struct packed {
    logic       load;
    logic       div_step;
    logic       digit_done;
    logic       prep;
    logic       pad_dec;
    logic       dig_adv;
    logic       emit;
    emit_kind_e kind;
  } irt_cmd_t;

  typedef struct packed {
    logic div_done;
    logic neg;
    logic pad_need;
    logic pad_last;
    logic idx_zero;
  } irt_stat_t;

  function automatic logic [CHAR_W-1:0] glyph(input logic [RADIX_W-1:0] d);
    logic [RADIX_W-1:0] ds;
    ds = (d > DIGIT_MAX) ? DIGIT_MAX : d;
    if (ds < 6'd10) begin
      return CH_ZERO + CHAR_W'(ds);
    end
    return CH_UPPER + CHAR_W'(ds - 6'd10);
  endfunction

endpackage

@@ src/integer_to_radix_text.sv @@
// Converts one integer to ASCII text in radix 2..36, most significant character first.
// Pulse start_i while busy_o is low to hand in an item; characters then come out one per
// cycle on char_code_o with char_valid_o high for one cycle each, last_char_o marking the
// final one. The receiver cannot stall: every strobed character must be taken that cycle.
// An item first runs through the shared divider (one digit per pass, eight quotient
// bits per cycle), then the digit memory read, then the characters one per cycle (sign,
// pad zeros, digits). busy_o drops as the last character appears; a new start_i may
// follow at once.
module integer_to_radix_text #(
  parameter int VALUE_WIDTH = irt_pkg::DEF_VALUE_WIDTH,
  parameter int MAX_PAD     = irt_pkg::DEF_MAX_PAD
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [VALUE_WIDTH-1:0]       value_bits_i,
  input  logic                         signed_mode_i,
  input  logic [irt_pkg::RADIX_W-1:0]  radix_i,
  input  logic [irt_pkg::PAD_IN_W-1:0] pad_width_i,
  output logic                         char_valid_o,
  output logic [irt_pkg::CHAR_W-1:0]   char_code_o,
  output logic                         last_char_o
);
  import irt_pkg::*;

  irt_cmd_t  cmd;
  irt_stat_t stat;

  irt_ctrl #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy_o),
    .valid_o(char_valid_o)
  );

  irt_dpath #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .MAX_PAD    (MAX_PAD)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .value_bits_i (value_bits_i),
    .signed_mode_i(signed_mode_i),
    .radix_i      (radix_i),
    .pad_width_i  (pad_width_i),
    .char_code_o  (char_code_o),
    .last_char_o  (last_char_o)
  );

endmodule

@@ src/irt_ctrl.sv @@
module irt_ctrl #(
  parameter int VALUE_WIDTH = irt_pkg::DEF_VALUE_WIDTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  irt_pkg::irt_stat_t stat_i,
  output irt_pkg::irt_cmd_t  cmd_o,
  output logic              busy_o,
  output logic              valid_o
);
  import irt_pkg::*;

  localparam int DIV_CYCLES = (VALUE_WIDTH + DIV_STEPS - 1) / DIV_STEPS;
  localparam int CYC_W      = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
  localparam logic [CYC_W-1:0] CYC_LAST = CYC_W'(DIV_CYCLES - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_PREP,
    ST_SIGN,
    ST_PAD,
    ST_DIGIT
  } state_e;

  state_e           state_q, state_d;
  logic [CYC_W-1:0] cyc_q, cyc_d;
  logic             valid_q, valid_d;

  always_comb begin
    state_d = state_q;
    cyc_d   = cyc_q;
    cmd_o   = '0;
    cmd_o.kind = EMIT_PAD;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          cyc_d      = '0;
          state_d    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cyc_q == CYC_LAST) begin
          cmd_o.digit_done = 1'b1;
          cyc_d            = '0;
          if (stat_i.div_done) begin
            state_d = ST_PREP;
          end
        end else begin
          cyc_d = cyc_q + CYC_W'(1);
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        if (stat_i.neg) begin
          state_d = ST_SIGN;
        end else if (stat_i.pad_need) begin
          state_d = ST_PAD;
        end else begin
          state_d = ST_DIGIT;
        end
      end
      ST_SIGN: begin
        cmd_o.emit = 1'b1;
        cmd_o.kind = EMIT_SIGN;
        state_d    = stat_i.pad_need ? ST_PAD : ST_DIGIT;
      end
      ST_PAD: begin
        cmd_o.emit    = 1'b1;
        cmd_o.kind    = EMIT_PAD;
        cmd_o.pad_dec = 1'b1;
        if (stat_i.pad_last) begin
          state_d = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        cmd_o.emit    = 1'b1;
        cmd_o.kind    = EMIT_DIGIT;
        cmd_o.dig_adv = 1'b1;
        if (stat_i.idx_zero) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    valid_d = cmd_o.emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cyc_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cyc_q   <= cyc_d;
      valid_q <= valid_d;
    end
  end

  assign busy_o  = (state_q != ST_IDLE);
  assign valid_o = valid_q;

endmodule

@@ src/irt_dpath.sv @@
module irt_dpath #(
  parameter int VALUE_WIDTH = irt_pkg::DEF_VALUE_WIDTH,
  parameter int MAX_PAD     = irt_pkg::DEF_MAX_PAD
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  irt_pkg::irt_cmd_t            cmd_i,
  output irt_pkg::irt_stat_t           stat_o,
  input  logic [VALUE_WIDTH-1:0]       value_bits_i,
  input  logic                         signed_mode_i,
  input  logic [irt_pkg::RADIX_W-1:0]  radix_i,
  input  logic [irt_pkg::PAD_IN_W-1:0] pad_width_i,
  output logic [irt_pkg::CHAR_W-1:0]   char_code_o,
  output logic                         last_char_o
);
  import irt_pkg::*;

  localparam int DIV_CYCLES = (VALUE_WIDTH + DIV_STEPS - 1) / DIV_STEPS;
  localparam int DW         = DIV_CYCLES * DIV_STEPS;
  localparam int DEPTH      = VALUE_WIDTH;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int CMP_W      = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  logic [RADIX_W-1:0]     mem_q [DEPTH];
  logic [RADIX_W-1:0]     rd_q;
  logic [IDX_W-1:0]       rd_addr;

  logic [DW-1:0]          sh_q, sh_nxt;
  logic [RADIX_W-1:0]     part_q, part_nxt;
  logic [RADIX_W:0]       trial;
  logic [RADIX_W-1:0]     radix_q;
  logic [LEN_W-1:0]       pad_q;
  logic [LEN_W-1:0]       pad_left_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [CNT_W-1:0]       cnt_m1;
  logic [IDX_W-1:0]       out_idx_q;
  logic                   neg_q;
  logic [CHAR_W-1:0]      char_q, char_d;
  logic                   last_q, last_d;

  logic                   neg_in;
  logic [VALUE_WIDTH-1:0] mag_in;
  logic [RADIX_W-1:0]     radix_sat;
  logic [LEN_W-1:0]       pad_sat;

  assign neg_in = signed_mode_i & value_bits_i[VALUE_WIDTH-1];
  assign mag_in = neg_in ? (~value_bits_i + VALUE_WIDTH'(1)) : value_bits_i;

  always_comb begin
    if (radix_i < RADIX_MIN) begin
      radix_sat = RADIX_MIN;
    end else if (radix_i > RADIX_MAX) begin
      radix_sat = RADIX_MAX;
    end else begin
      radix_sat = radix_i;
    end
    if (CMP_W'(pad_width_i) > CMP_W'(MAX_PAD)) begin
      pad_sat = LEN_W'(MAX_PAD);
    end else begin
      pad_sat = LEN_W'(pad_width_i);
    end
  end

  // Restoring division, DIV_STEPS quotient bits per cycle
  always_comb begin
    part_nxt = part_q;
    sh_nxt   = sh_q;
    trial    = '0;
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial  = {part_nxt, sh_nxt[DW-1]};
      sh_nxt = {sh_nxt[DW-2:0], 1'b0};
      if (trial >= {1'b0, radix_q}) begin
        part_nxt  = RADIX_W'(trial - {1'b0, radix_q});
        sh_nxt[0] = 1'b1;
      end else begin
        part_nxt = trial[RADIX_W-1:0];
      end
    end
  end

  assign cnt_m1 = cnt_q - CNT_W'(1);

  always_comb begin
    if (cmd_i.prep) begin
      rd_addr = cnt_m1[IDX_W-1:0];
    end else if (cmd_i.dig_adv) begin
      rd_addr = out_idx_q - IDX_W'(1);
    end else begin
      rd_addr = out_idx_q;
    end
  end

  always_comb begin
    char_d = char_q;
    last_d = last_q;
    if (cmd_i.emit) begin
      case (cmd_i.kind)
        EMIT_SIGN: begin
          char_d = CH_MINUS;
          last_d = 1'b0;
        end
        EMIT_DIGIT: begin
          char_d = glyph(rd_q);
          last_d = (out_idx_q == '0);
        end
        default: begin
          char_d = CH_ZERO;
          last_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      neg_q      <= 1'b0;
      pad_left_q <= '0;
      out_idx_q  <= '0;
    end else begin
      if (cmd_i.load) begin
        cnt_q <= '0;
        neg_q <= neg_in;
      end else if (cmd_i.digit_done) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (cmd_i.prep) begin
        pad_left_q <= pad_q - LEN_W'(cnt_q);
        out_idx_q  <= cnt_m1[IDX_W-1:0];
      end else begin
        if (cmd_i.pad_dec) begin
          pad_left_q <= pad_left_q - LEN_W'(1);
        end
        if (cmd_i.dig_adv) begin
          out_idx_q <= out_idx_q - IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sh_q    <= DW'(mag_in);
      part_q  <= '0;
      radix_q <= radix_sat;
      pad_q   <= pad_sat;
    end else if (cmd_i.div_step) begin
      sh_q   <= sh_nxt;
      part_q <= cmd_i.digit_done ? '0 : part_nxt;
    end
    char_q <= char_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.digit_done) begin
      mem_q[cnt_q[IDX_W-1:0]] <= part_nxt;
    end
    rd_q <= mem_q[rd_addr];
  end

  assign stat_o.div_done = (sh_nxt == '0) || (cnt_q == CNT_W'(DEPTH - 1));
  assign stat_o.neg      = neg_q;
  assign stat_o.pad_need = (CMP_W'(pad_q) > CMP_W'(cnt_q));
  assign stat_o.pad_last = (pad_left_q == LEN_W'(1));
  assign stat_o.idx_zero = (out_idx_q == '0);

  assign char_code_o = char_q;
  assign last_char_o = last_q;

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import irt_pkg::*;

  localparam int VW = 32;
  localparam int PAD_CAP = 32;
  localparam int CYCLE_LIMIT = 600000;
  localparam int MAX_REPORTS = 50;
  localparam string DIGIT_TEXT = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic [VW-1:0]       value_bits_i = '0;
  logic                signed_mode_i = 1'b0;
  logic [RADIX_W-1:0]  radix_i = RADIX_MIN;
  logic [PAD_IN_W-1:0] pad_width_i = '0;
  logic                busy_o;
  logic                char_valid_o;
  logic [CHAR_W-1:0]   char_code_o;
  logic                last_char_o;

  text_char_t  pending_chars[$];
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;

  integer_to_radix_text u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .value_bits_i (value_bits_i),
    .signed_mode_i(signed_mode_i),
    .radix_i      (radix_i),
    .pad_width_i  (pad_width_i),
    .char_valid_o (char_valid_o),
    .char_code_o  (char_code_o),
    .last_char_o  (last_char_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  task automatic report_mismatch(input string msg);
    if (err_count < MAX_REPORTS) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    err_count++;
  endtask

  function automatic void push_char(input logic [CHAR_W-1:0] code, input logic last);
    text_char_t tc;
    tc.code = code;
    tc.last = last;
    pending_chars.push_back(tc);
  endfunction

  // expected text of one number, queued in emission order
  function automatic void render_text(input logic [VW-1:0] value, input logic is_signed,
                                      input logic [RADIX_W-1:0] radix_raw,
                                      input logic [PAD_IN_W-1:0] pad_raw);
    logic [VW-1:0]      mag;
    logic [RADIX_W-1:0] base;
    logic [RADIX_W-1:0] digs[VW];
    logic               neg;
    int unsigned        pad;
    int unsigned        ndig;
    int unsigned        total;
    base = (radix_raw < RADIX_MIN) ? RADIX_MIN :
           (radix_raw > RADIX_MAX) ? RADIX_MAX : radix_raw;
    pad = (pad_raw > PAD_CAP) ? PAD_CAP : pad_raw;
    neg = is_signed & value[VW-1];
    mag = neg ? (~value + 1'b1) : value;
    ndig = 0;
    do begin
      digs[ndig] = RADIX_W'(mag % base);
      ndig++;
      mag = mag / base;
    end while (mag != '0 && ndig < VW);
    total = (ndig > pad) ? ndig : pad;
    if (neg) begin
      push_char(CH_MINUS, 1'b0);
    end
    for (int i = ndig; i < total; i++) begin
      push_char(CH_ZERO, 1'b0);
    end
    for (int i = ndig; i > 0; i--) begin
      push_char(CHAR_W'(DIGIT_TEXT[digs[i-1]]), i == 1);
    end
  endfunction

  // checks strobed characters, then queues the text of an item taken at this edge
  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni) begin
      if (char_valid_o) begin
        if (pending_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected char %h last %b", char_code_o, last_char_o));
        end else begin
          want = pending_chars.pop_front();
          if (char_code_o !== want.code) begin
            report_mismatch($sformatf("char_code got %h exp %h", char_code_o, want.code));
          end
          if (last_char_o !== want.last) begin
            report_mismatch($sformatf("last_char got %b exp %b", last_char_o, want.last));
          end
        end
      end
      if (start_i && !busy_o) begin
        render_text(value_bits_i, signed_mode_i, radix_i, pad_width_i);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL integer_to_radix_text");
      $finish;
    end
  end

  // start stays high after the item is taken unless a gap follows
  task automatic send_item(input logic [VW-1:0] v, input logic s,
                           input logic [RADIX_W-1:0] r, input logic [PAD_IN_W-1:0] p,
                           input bit may_idle);
    start_i       <= 1'b1;
    value_bits_i  <= v;
    signed_mode_i <= s;
    radix_i       <= r;
    pad_width_i   <= p;
    do @(posedge clk_i); while (busy_o);
    if (may_idle && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_chars.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [VW-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 40);
      2: return 32'hFFFF_FFFF - $urandom_range(0, 40);
      3: return 32'h8000_0000 + $urandom_range(0, 40);
      4: return 32'h7FFF_FFFF - $urandom_range(0, 40);
      default: return $urandom() >> $urandom_range(0, 31);
    endcase
  endfunction

  task automatic send_random(input bit may_idle);
    logic [RADIX_W-1:0]  r;
    logic [PAD_IN_W-1:0] p;
    r = ($urandom_range(0, 9) == 0) ? RADIX_W'($urandom_range(0, 63)) :
                                      RADIX_W'($urandom_range(2, 36));
    case ($urandom_range(0, 6))
      0: p = PAD_IN_W'($urandom_range(0, 63));
      1, 2: p = PAD_IN_W'($urandom_range(0, 32));
      default: p = PAD_IN_W'($urandom_range(0, 10));
    endcase
    send_item(pick_value(), 1'($urandom_range(0, 1)), r, p, may_idle);
  endtask

  task automatic test_extremes();
    send_item(32'h0, 1'b0, 6'd10, 6'd0, 1'b1);
    send_item(32'h0, 1'b1, 6'd2, 6'd32, 1'b1);
    send_item(32'hFFFF_FFFF, 1'b0, 6'd2, 6'd0, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b1, 6'd10, 6'd0, 1'b1);
    send_item(32'h8000_0000, 1'b1, 6'd2, 6'd32, 1'b0);
    send_item(32'h8000_0000, 1'b1, 6'd36, 6'd0, 1'b1);
    send_item(32'h8000_0000, 1'b0, 6'd16, 6'd0, 1'b1);
    send_item(32'h7FFF_FFFF, 1'b1, 6'd16, 6'd0, 1'b0);
    send_item(32'd35, 1'b0, 6'd36, 6'd1, 1'b1);
    send_item(32'hFFFF_FFFF, 1'b0, 6'd36, 6'd0, 1'b1);
    send_item(32'd511, 1'b1, 6'd8, 6'd3, 1'b0);
    wait_drained();
  endtask

  // radix below two or above 36 and pad above the cap saturate
  task automatic test_saturation();
    send_item(32'd37, 1'b0, 6'd0, 6'd0, 1'b1);
    send_item(32'hFFFF_FFF0, 1'b1, 6'd1, 6'd4, 1'b0);
    send_item(32'd1295, 1'b0, 6'd37, 6'd0, 1'b1);
    send_item(32'hDEAD_BEEF, 1'b1, 6'd63, 6'd0, 1'b1);
    send_item(32'd7, 1'b0, 6'd10, 6'd33, 1'b0);
    send_item(32'hFFFF_FFF9, 1'b1, 6'd10, 6'd63, 1'b1);
    wait_drained();
  endtask

  task automatic test_padding();
    send_item(32'd12345, 1'b0, 6'd10, 6'd5, 1'b0);
    send_item(32'd12345, 1'b0, 6'd10, 6'd4, 1'b1);
    send_item(32'hFFFF_FFFE, 1'b1, 6'd10, 6'd6, 1'b0);
    send_item(32'h0, 1'b0, 6'd16, 6'd1, 1'b1);
    send_item(32'h0, 1'b1, 6'd36, 6'd63, 1'b1);
    wait_drained();
  endtask

  task automatic test_pressure();
    repeat (3) begin
      repeat (3) send_random(1'b1);
      wait_drained();
    end
  endtask

  task automatic test_random();
    bit idle_on;
    idle_on = 1'b1;
    repeat (340) begin
      if ($urandom_range(0, 29) == 0) begin
        idle_on = !idle_on;
      end
      send_random(idle_on);
    end
  endtask

  task automatic test_back_to_back();
    repeat (40) send_random(1'b0);
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_saturation();
    test_padding();
    test_pressure();
    test_random();
    test_back_to_back();
    repeat (200) @(posedge clk_i);
    if (err_count == 0 && pending_chars.size() == 0) begin
      $display("PASS integer_to_radix_text");
    end else begin
      $display("FAIL integer_to_radix_text");
    end
    $finish;
  end

endmodule
